[hw/rtl/czm_pkg.sv]
// Package for the column zone map statistics block.
// Holds the item structs, request/compare/selectivity codes and store interface types.
// No dependencies.
package czm_pkg;

	localparam int COL_IDX_W = 3;
	localparam int COL_SPACE = 2 ** COL_IDX_W;
	localparam int NUM_COL_W = 4;

	localparam logic [1:0] REQ_ADD        = 2'd0;
	localparam logic [1:0] REQ_QUERY      = 2'd1;
	localparam logic [1:0] REQ_INVALIDATE = 2'd2;
	localparam logic [1:0] REQ_CLEAR      = 2'd3;

	localparam logic [2:0] OP_EQ = 3'd0;
	localparam logic [2:0] OP_LT = 3'd1;
	localparam logic [2:0] OP_LE = 3'd2;
	localparam logic [2:0] OP_GT = 3'd3;
	localparam logic [2:0] OP_GE = 3'd4;

	localparam logic [1:0] SEL_UNKNOWN = 2'd0;
	localparam logic [1:0] SEL_NONE    = 2'd1;
	localparam logic [1:0] SEL_SOME    = 2'd2;
	localparam logic [1:0] SEL_ALL     = 2'd3;

	typedef struct packed {
		logic [1:0]           req_type;
		logic [COL_IDX_W-1:0] column_index;
		logic signed [63:0]   column_value;
		logic                 value_is_null;
		logic [15:0]          record_id;
		logic                 row_last;
		logic [2:0]           compare_op;
		logic signed [63:0]   literal;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         selectivity;
		logic signed [63:0] min_out;
		logic signed [63:0] max_out;
		logic signed [63:0] sum_out;
		logic [31:0]        rows_out;
		logic [15:0]        min_tuple_out;
		logic [15:0]        max_tuple_out;
	} rsp_item_t;

	// update command into the column store
	typedef struct packed {
		logic               add;
		logic               clear;
		logic signed [63:0] value;
		logic [15:0]        tid;
	} czm_upd_t;

	// one column entry as read from the store
	typedef struct packed {
		logic               valid;
		logic signed [63:0] min_val;
		logic signed [63:0] max_val;
		logic signed [63:0] sum_val;
		logic [15:0]        min_tid;
		logic [15:0]        max_tid;
	} czm_entry_t;

endpackage

[hw/rtl/czm_stats_store.sv]
// Per-column statistics registers: min/max with tuple ids, wrapping sum, valid mark.
// One read port (combinational), one update port. Depends on czm_pkg.
module czm_stats_store #(
	parameter int DEPTH = 8,
	localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  czm_pkg::czm_upd_t   upd,
	input  logic [IdxW-1:0]     wr_idx,
	input  logic [IdxW-1:0]     rd_idx,
	output czm_pkg::czm_entry_t rd
);

	logic                valid_q   [DEPTH];
	logic signed [63:0]  sum_q     [DEPTH];
	logic signed [63:0]  min_q     [DEPTH];
	logic signed [63:0]  max_q     [DEPTH];
	logic [15:0]         min_tid_q [DEPTH];
	logic [15:0]         max_tid_q [DEPTH];

	logic new_min;
	logic new_max;

	assign new_min = !valid_q[wr_idx] || (upd.value < min_q[wr_idx]);
	assign new_max = !valid_q[wr_idx] || (max_q[wr_idx] < upd.value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				valid_q[i] <= 1'b0;
				sum_q[i]   <= '0;
			end
		end else if (upd.clear) begin
			for (int i = 0; i < DEPTH; i++) begin
				valid_q[i] <= 1'b0;
				sum_q[i]   <= '0;
			end
		end else if (upd.add) begin
			valid_q[wr_idx] <= 1'b1;
			sum_q[wr_idx]   <= sum_q[wr_idx] + upd.value;
		end
	end

	// extremes need no reset: valid mark gates them
	always_ff @(posedge clk) begin
		if (upd.add && new_min) begin
			min_q[wr_idx]     <= upd.value;
			min_tid_q[wr_idx] <= upd.tid;
		end
		if (upd.add && new_max) begin
			max_q[wr_idx]     <= upd.value;
			max_tid_q[wr_idx] <= upd.tid;
		end
	end

	assign rd.valid   = valid_q[rd_idx];
	assign rd.min_val = min_q[rd_idx];
	assign rd.max_val = max_q[rd_idx];
	assign rd.sum_val = sum_q[rd_idx];
	assign rd.min_tid = min_tid_q[rd_idx];
	assign rd.max_tid = max_tid_q[rd_idx];

endmodule

[hw/rtl/czm_judge.sv]
// Predicate judge: classifies a literal compare against a column's [min, max] range.
// Purely combinational. Depends on czm_pkg.
module czm_judge (
	input  logic [2:0]         op,
	input  logic signed [63:0] lit,
	input  logic signed [63:0] lo,
	input  logic signed [63:0] hi,
	output logic [1:0]         sel
);

	logic lit_lt_lo;
	logic lit_lt_hi;
	logic hi_lt_lit;
	logic lo_lt_lit;

	assign lit_lt_lo = lit < lo;
	assign lit_lt_hi = lit < hi;
	assign hi_lt_lit = hi < lit;
	assign lo_lt_lit = lo < lit;

	always_comb begin
		case (op)
			czm_pkg::OP_EQ: begin
				sel = (lit_lt_lo || hi_lt_lit) ? czm_pkg::SEL_NONE : czm_pkg::SEL_SOME;
			end
			czm_pkg::OP_LT: begin
				if (hi_lt_lit)      sel = czm_pkg::SEL_ALL;
				else if (!lo_lt_lit) sel = czm_pkg::SEL_NONE;
				else                sel = czm_pkg::SEL_SOME;
			end
			czm_pkg::OP_LE: begin
				if (!lit_lt_hi)     sel = czm_pkg::SEL_ALL;
				else if (lit_lt_lo) sel = czm_pkg::SEL_NONE;
				else                sel = czm_pkg::SEL_SOME;
			end
			czm_pkg::OP_GT: begin
				if (lit_lt_lo)       sel = czm_pkg::SEL_ALL;
				else if (!lit_lt_hi) sel = czm_pkg::SEL_NONE;
				else                 sel = czm_pkg::SEL_SOME;
			end
			czm_pkg::OP_GE: begin
				if (!lo_lt_lit)     sel = czm_pkg::SEL_ALL;
				else if (hi_lt_lit) sel = czm_pkg::SEL_NONE;
				else                sel = czm_pkg::SEL_SOME;
			end
			default: begin
				sel = czm_pkg::SEL_UNKNOWN;
			end
		endcase
	end

endmodule

[hw/rtl/column_zone_map_stats.sv]
// Top level of the column zone map statistics block.
// Instantiates czm_stats_store and czm_judge; depends on czm_pkg.

// Zone map over up to MAX_COLUMNS signed 64-bit columns (only the first eight are
// addressable by the 3-bit column index). Every request is a single transfer on the
// req channel; only a query produces a transfer on the rsp channel. Throughput is one
// request per clock while no query is held back: a request is captured in the input
// stage, does its read-modify-write of the column registers (one signed compare pair
// and one 64-bit add) in that same cycle, and a query's answer lands in the output
// register. A query result is therefore registered, and the input
// stage keeps taking requests while a result waits, stalling only a second query
// that finds the output register full and not being drained. Clear empties all
// entries and the row count; there is no clearing pass after reset.
// num_columns is written through the cfg channel, which is always ready; write it
// only when no request is in flight.
module column_zone_map_stats #(
	parameter int MAX_COLUMNS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  czm_pkg::req_item_t      req,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output czm_pkg::rsp_item_t      rsp,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [czm_pkg::NUM_COL_W-1:0] cfg_data
);

	// Storage beyond the index space can never be reached.
	localparam int Depth = (MAX_COLUMNS < czm_pkg::COL_SPACE) ? MAX_COLUMNS
		: czm_pkg::COL_SPACE;
	localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam logic [6:0] MaxCols = 7'(MAX_COLUMNS);

	// configuration
	logic [czm_pkg::NUM_COL_W-1:0] num_columns_q;

	// input stage
	czm_pkg::req_item_t req_s1;
	logic               valid_s1;

	// shared state
	logic        consistent_q;
	logic [31:0] row_cnt_q;

	// output register
	czm_pkg::rsp_item_t rsp_q;
	logic               rsp_valid_q;

	logic                is_add;
	logic                is_query;
	logic                is_inval;
	logic                is_clear;
	logic                in_range;
	logic                s1_adv;
	logic [IdxW-1:0]     col_idx;
	czm_pkg::czm_upd_t   upd;
	czm_pkg::czm_entry_t ent;
	logic [1:0]          judged;
	czm_pkg::rsp_item_t  rsp_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_columns_q <= czm_pkg::NUM_COL_W'(1);
		end else if (cfg_valid) begin
			num_columns_q <= cfg_data;
		end
	end

	// --- input stage ---------------------------------------------------------
	assign is_add   = valid_s1 && (req_s1.req_type == czm_pkg::REQ_ADD);
	assign is_query = valid_s1 && (req_s1.req_type == czm_pkg::REQ_QUERY);
	assign is_inval = valid_s1 && (req_s1.req_type == czm_pkg::REQ_INVALIDATE);
	assign is_clear = valid_s1 && (req_s1.req_type == czm_pkg::REQ_CLEAR);

	// only a query can be held back, and only by a full, undrained output register
	assign s1_adv    = !is_query || !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// effective column count is min(num_columns, MAX_COLUMNS)
	assign in_range = (czm_pkg::NUM_COL_W'(req_s1.column_index) < num_columns_q)
		&& (7'(req_s1.column_index) < MaxCols);
	assign col_idx  = req_s1.column_index[IdxW-1:0];

	// --- column statistics update --------------------------------------------
	assign upd.add   = is_add && consistent_q && in_range && !req_s1.value_is_null;
	assign upd.clear = is_clear;
	assign upd.value = req_s1.column_value;
	assign upd.tid   = req_s1.record_id;

	czm_stats_store #(
		.DEPTH (Depth)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.wr_idx (col_idx),
		.rd_idx (col_idx),
		.rd     (ent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			consistent_q <= 1'b0;
			row_cnt_q    <= '0;
		end else begin
			if (is_clear) begin
				consistent_q <= 1'b1;
				row_cnt_q    <= '0;
			end else if (is_inval) begin
				consistent_q <= 1'b0;
			end else if (is_add && consistent_q && req_s1.row_last) begin
				// null or out-of-range values still count their row
				row_cnt_q <= row_cnt_q + 32'd1;
			end
		end
	end

	// --- query ---------------------------------------------------------------
	czm_judge u_judge (
		.op  (req_s1.compare_op),
		.lit (req_s1.literal),
		.lo  (ent.min_val),
		.hi  (ent.max_val),
		.sel (judged)
	);

	always_comb begin
		rsp_d               = '0;
		rsp_d.rows_out      = row_cnt_q;
		rsp_d.selectivity   = czm_pkg::SEL_UNKNOWN;
		if (in_range) begin
			rsp_d.sum_out = ent.sum_val;
			if (ent.valid) begin
				rsp_d.min_out       = ent.min_val;
				rsp_d.max_out       = ent.max_val;
				rsp_d.min_tuple_out = ent.min_tid;
				rsp_d.max_tuple_out = ent.max_tid;
				if (consistent_q) begin
					rsp_d.selectivity = judged;
				end
			end
		end
	end

	// --- output register -----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (is_query && s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_query && s1_adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[tb/tb_column_zone_map_stats.sv]
`timescale 1ns / 1ps
// Self-checking testbench for column_zone_map_stats: streams add, query, invalidate and
// clear requests with random gaps and stalls, predicts each query answer field by field.
// Depends on czm_pkg and the column_zone_map_stats RTL.
module tb_column_zone_map_stats;

	localparam int COLS        = 8;
	localparam int CYCLE_LIMIT = 200000;  // watchdog bound for the whole run
	localparam int SETTLE      = 4;       // last request leaves the input stage next cycle
	localparam int PER_PHASE   = 80;      // counted requests per column setting

	localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic [2:0]         OP_UNDEF = 3'd7;  // any code past OP_GE judges unknown

	// Predicted zone map plus the queue of query answers still owed by the block.
	class zone_stats_book;
		logic [3:0]         col_setting;
		bit                 fresh;        // map consistent: adds take effect
		bit                 has_entry [COLS];
		logic signed [63:0] lo [COLS];
		logic signed [63:0] hi [COLS];
		logic signed [63:0] total [COLS];
		logic [15:0]        lo_tid [COLS];
		logic [15:0]        hi_tid [COLS];
		logic [31:0]        rows;
		czm_pkg::rsp_item_t pending_answers [$];
		int                 errors;
		int                 answers_checked;

		function new();
			col_setting = 4'd1;
			fresh = 1'b0;
			rows = '0;
			errors = 0;
			answers_checked = 0;
			foreach (has_entry[i]) begin
				has_entry[i] = 1'b0;
				lo[i] = '0;
				hi[i] = '0;
				total[i] = '0;
				lo_tid[i] = '0;
				hi_tid[i] = '0;
			end
		endfunction

		function bit column_live(input logic [2:0] col);
			int n;
			n = (col_setting > COLS) ? COLS : col_setting;
			return col < n;
		endfunction

		// none/some/all from the column's min and max against the literal
		function logic [1:0] predict_selectivity(input logic [2:0] op,
				input logic signed [63:0] lit, input logic signed [63:0] l,
				input logic signed [63:0] h);
			case (op)
				czm_pkg::OP_EQ: return (lit < l || lit > h) ? czm_pkg::SEL_NONE
					: czm_pkg::SEL_SOME;
				czm_pkg::OP_LT: begin
					if (h < lit) return czm_pkg::SEL_ALL;
					if (l >= lit) return czm_pkg::SEL_NONE;
					return czm_pkg::SEL_SOME;
				end
				czm_pkg::OP_LE: begin
					if (lit >= h) return czm_pkg::SEL_ALL;
					if (lit < l) return czm_pkg::SEL_NONE;
					return czm_pkg::SEL_SOME;
				end
				czm_pkg::OP_GT: begin
					if (lit < l) return czm_pkg::SEL_ALL;
					if (lit >= h) return czm_pkg::SEL_NONE;
					return czm_pkg::SEL_SOME;
				end
				czm_pkg::OP_GE: begin
					if (l >= lit) return czm_pkg::SEL_ALL;
					if (h < lit) return czm_pkg::SEL_NONE;
					return czm_pkg::SEL_SOME;
				end
				default: return czm_pkg::SEL_UNKNOWN;
			endcase
		endfunction

		// Applies one accepted request; returns 0 for an add the block ignores.
		function bit absorb_request(input czm_pkg::req_item_t it);
			czm_pkg::rsp_item_t ans;
			int                 c;
			bit                 live;
			c = int'(it.column_index);
			live = column_live(it.column_index);
			case (it.req_type)
				czm_pkg::REQ_ADD: begin
					if (!fresh) return 1'b0;
					if (live && !it.value_is_null) begin
						total[c] += it.column_value;
						if (!has_entry[c]) begin
							lo[c] = it.column_value;
							hi[c] = it.column_value;
							lo_tid[c] = it.record_id;
							hi_tid[c] = it.record_id;
							has_entry[c] = 1'b1;
						end else begin
							// ties keep the tuple that got there first
							if (it.column_value < lo[c]) begin
								lo[c] = it.column_value;
								lo_tid[c] = it.record_id;
							end
							if (it.column_value > hi[c]) begin
								hi[c] = it.column_value;
								hi_tid[c] = it.record_id;
							end
						end
					end
					if (it.row_last) rows++;
				end
				czm_pkg::REQ_INVALIDATE: fresh = 1'b0;
				czm_pkg::REQ_CLEAR: begin
					foreach (has_entry[i]) begin
						has_entry[i] = 1'b0;
						total[i] = '0;
					end
					rows = '0;
					fresh = 1'b1;
				end
				czm_pkg::REQ_QUERY: begin
					ans = '0;
					ans.rows_out = rows;
					if (live) begin
						ans.sum_out = total[c];
						if (has_entry[c]) begin
							ans.min_out = lo[c];
							ans.max_out = hi[c];
							ans.min_tuple_out = lo_tid[c];
							ans.max_tuple_out = hi_tid[c];
							if (fresh)
								ans.selectivity = predict_selectivity(it.compare_op,
									it.literal, lo[c], hi[c]);
						end
					end
					pending_answers.push_back(ans);
				end
			endcase
			return 1'b1;
		endfunction

		task log_mismatch(input string msg);
			$display("[%0t] answer %0d: %s", $realtime, answers_checked, msg);
			errors++;
		endtask

		task match_answer(input czm_pkg::rsp_item_t got);
			czm_pkg::rsp_item_t want;
			if (pending_answers.size() == 0) begin
				log_mismatch($sformatf("answer with no query waiting, selectivity %0d",
					got.selectivity));
				return;
			end
			want = pending_answers.pop_front();
			answers_checked++;
			if (got.selectivity !== want.selectivity)
				log_mismatch($sformatf("selectivity got %0d want %0d",
					got.selectivity, want.selectivity));
			if (got.min_out !== want.min_out)
				log_mismatch($sformatf("min_out got %0d want %0d", got.min_out, want.min_out));
			if (got.max_out !== want.max_out)
				log_mismatch($sformatf("max_out got %0d want %0d", got.max_out, want.max_out));
			if (got.sum_out !== want.sum_out)
				log_mismatch($sformatf("sum_out got %0d want %0d", got.sum_out, want.sum_out));
			if (got.rows_out !== want.rows_out)
				log_mismatch($sformatf("rows_out got %0d want %0d",
					got.rows_out, want.rows_out));
			if (got.min_tuple_out !== want.min_tuple_out)
				log_mismatch($sformatf("min_tuple_out got %h want %h",
					got.min_tuple_out, want.min_tuple_out));
			if (got.max_tuple_out !== want.max_tuple_out)
				log_mismatch($sformatf("max_tuple_out got %h want %h",
					got.max_tuple_out, want.max_tuple_out));
		endtask
	endclass

	// DUT-facing signals; every input starts at a known value
	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          req_valid = 1'b0;
	logic                          req_ready;
	czm_pkg::req_item_t            req       = '0;
	logic                          rsp_valid;
	logic                          rsp_ready = 1'b1;
	czm_pkg::rsp_item_t            rsp;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [czm_pkg::NUM_COL_W-1:0] cfg_data  = '0;

	zone_stats_book     sb;
	bit                 no_idle = 1'b0;     // phases with back-to-back transfers on both sides
	int                 cycles = 0;
	int                 answer_hold = 0;
	int                 requests_sent = 0;
	int                 settings_used = 0;
	logic signed [63:0] value_base = '0;    // center of the clustered values of a phase

	// Column settings per phase: full width, single column, above MAX_COLUMNS, none, partial widths.
	int col_plan [13] = '{8, 1, 15, 0, 3, 8, 5, 2, 12, 7, 4, 6, 8};

	column_zone_map_stats #(.MAX_COLUMNS(COLS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("column_zone_map_stats: mismatch");
			$finish;
		end
	end

	function automatic int draw_wait();
		if (no_idle) return 0;
		return $urandom_range(0, 4);
	endfunction

	// Result side: check every transfer, then hold ready low for a freshly drawn
	// wait, if any. Outputs are sampled before this edge's register updates.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			sb.match_answer(rsp);
			answer_hold = draw_wait();
			if (answer_hold > 0) rsp_ready <= 1'b0;
		end else if (!rsp_ready) begin
			answer_hold--;
			if (answer_hold <= 0) rsp_ready <= 1'b1;
		end
	end

	// Fully random request: every field, every bit, any kind.
	function automatic czm_pkg::req_item_t noise_item();
		czm_pkg::req_item_t it;
		it.req_type      = 2'($urandom_range(0, 3));
		it.column_index  = 3'($urandom_range(0, COLS - 1));
		it.column_value  = {$urandom, $urandom};
		it.value_is_null = 1'($urandom_range(0, 1));
		it.record_id     = 16'($urandom_range(0, 65535));
		it.row_last      = 1'($urandom_range(0, 1));
		it.compare_op    = 3'($urandom_range(0, 7));
		it.literal       = {$urandom, $urandom};
		return it;
	endfunction

	// One transfer on the request channel. Called at a rising edge; the valid
	// left high by the previous transfer is either reused (no gap) or dropped
	// here, so each edge sees at most one assignment to req_valid.
	task automatic send_request(input czm_pkg::req_item_t it);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (!req_ready);
		if (sb.absorb_request(it)) requests_sent++;
	endtask

	// Unused fields stay random so their bits toggle on every kind of request.
	task automatic send_add(input int col, input logic signed [63:0] val, input bit nul,
			input logic [15:0] tid, input bit last);
		czm_pkg::req_item_t it;
		it = noise_item();
		it.req_type      = czm_pkg::REQ_ADD;
		it.column_index  = 3'(col);
		it.column_value  = val;
		it.value_is_null = nul;
		it.record_id     = tid;
		it.row_last      = last;
		send_request(it);
	endtask

	task automatic send_query(input int col, input logic [2:0] op,
			input logic signed [63:0] lit);
		czm_pkg::req_item_t it;
		it = noise_item();
		it.req_type     = czm_pkg::REQ_QUERY;
		it.column_index = 3'(col);
		it.compare_op   = op;
		it.literal      = lit;
		send_request(it);
	endtask

	task automatic send_control(input logic [1:0] kind);
		czm_pkg::req_item_t it;
		it = noise_item();
		it.req_type = kind;
		send_request(it);
	endtask

	// Drop valid, wait out every owed answer, then let the pipeline go quiet:
	// trailing adds produce no answer but may still be in flight.
	task automatic settle_block();
		req_valid <= 1'b0;
		while (sb.pending_answers.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_columns(input logic [czm_pkg::NUM_COL_W-1:0] n);
		cfg_valid <= 1'b1;
		cfg_data <= n;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.col_setting = n;
		settings_used++;
	endtask

	// Mostly values clustered around the phase base so min/max ties and
	// literal hits on the bounds are common; some full-range values for wrap.
	function automatic logic signed [63:0] row_value();
		logic signed [63:0] offs;
		if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
		offs = 64'($urandom_range(0, 40));
		return value_base + offs - 64'sd20;
	endfunction

	// Literals that land on, just outside and between the stored bounds.
	function automatic logic signed [63:0] pick_literal(input int col);
		case ($urandom_range(0, 6))
			0: return sb.lo[col];
			1: return sb.hi[col];
			2: return sb.lo[col] - 64'sd1;
			3: return sb.hi[col] + 64'sd1;
			4: return row_value();
			5: return {$urandom, $urandom};
			default: return (sb.lo[col] >>> 1) + (sb.hi[col] >>> 1);
		endcase
	endfunction

	// One tuple: consecutive columns, the last one closing the row. A few
	// values go to a random column (possibly out of range) or are null.
	task automatic send_row();
		int          width;
		int          col;
		logic [15:0] tid;
		width = $urandom_range(1, COLS);
		tid = 16'($urandom_range(0, 65535));
		for (int c = 0; c < width; c++) begin
			col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, COLS - 1) : c;
			send_add(col, row_value(), $urandom_range(0, 9) == 0, tid, c == width - 1);
		end
	endtask

	task automatic send_random_query();
		int         col;
		logic [2:0] op;
		col = $urandom_range(0, COLS - 1);
		op = 3'(($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
		send_query(col, op, pick_literal(col));
	endtask

	initial begin
		int phase_start;
		int roll;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part, all eight columns live ----
		write_columns(4'd8);
		send_control(czm_pkg::REQ_INVALIDATE);        // flag already clear after reset
		send_add(0, 64'sd5, 1'b0, 16'h1234, 1'b1);    // ignored entirely, row not counted
		send_control(czm_pkg::REQ_CLEAR);
		send_add(0, VAL_MIN, 1'b0, 16'h0000, 1'b0);   // first value seeds min and max
		send_add(0, VAL_MAX, 1'b0, 16'hFFFF, 1'b0);
		// Every column gets written here: later queries never read a store
		// entry that was never written.
		for (int c = 1; c < COLS; c++)
			send_add(c, (c - 2) * 64'sd1000, 1'b0, 16'(c), c == COLS - 1);
		send_add(1, VAL_MAX, 1'b1, 16'hABCD, 1'b1);   // null: no stats, row still counts
		send_query(0, czm_pkg::OP_EQ, VAL_MIN);       // full range: some
		send_query(0, czm_pkg::OP_LT, VAL_MIN);       // none
		send_query(0, czm_pkg::OP_LE, VAL_MAX);       // all
		send_query(0, czm_pkg::OP_GT, 64'sd0);        // some
		send_query(0, czm_pkg::OP_GE, VAL_MIN);       // all
		send_query(0, OP_UNDEF, 64'sd0);              // unknown comparison
		send_query(2, czm_pkg::OP_EQ, 64'sd0);        // min == max == literal: some
		send_query(2, czm_pkg::OP_GT, 64'sd0);        // none
		send_control(czm_pkg::REQ_INVALIDATE);
		send_query(0, czm_pkg::OP_LT, 64'sd0);        // unknown, stats still reported
		send_add(0, 64'sd7, 1'b0, 16'h0001, 1'b1);    // ignored while inconsistent
		send_control(czm_pkg::REQ_CLEAR);
		send_query(1, czm_pkg::OP_EQ, 64'sd0);        // entry not valid: zeros, sum 0
		send_query(COLS - 1, czm_pkg::OP_GE, VAL_MAX);

		// ---- random phases, one column setting each ----
		for (int p = 0; p < $size(col_plan); p++) begin
			// Sender holds off until every answer is back before the write.
			settle_block();
			write_columns(czm_pkg::NUM_COL_W'(col_plan[p]));
			no_idle = (p % 5 == 3);
			case ($urandom_range(0, 3))
				0: value_base = '0;
				1: value_base = VAL_MIN + 64'sd10;
				2: value_base = VAL_MAX - 64'sd10;
				default: value_base = {$urandom, $urandom};
			endcase
			if ($urandom_range(0, 3) != 0) send_control(czm_pkg::REQ_CLEAR);
			phase_start = requests_sent;
			while (requests_sent - phase_start < PER_PHASE) begin
				roll = $urandom_range(0, 99);
				if (roll < 55)
					send_row();
				else if (roll < 85)
					send_random_query();
				else if (roll < 90) begin
					// broken rebuild: invalidate, a little traffic, then rebuild
					send_control(czm_pkg::REQ_INVALIDATE);
					repeat ($urandom_range(1, 3)) begin
						if ($urandom_range(0, 1)) send_row();
						else send_random_query();
					end
					send_control(czm_pkg::REQ_CLEAR);
				end else if (roll < 94)
					send_control(czm_pkg::REQ_CLEAR);
				else
					send_request(noise_item());
			end
		end
		no_idle = 1'b0;

		settle_block();
		$display("run covered %0d requests across %0d column settings",
			requests_sent, settings_used);
		$display("%0d query answers compared, %0d field disagreements",
			sb.answers_checked, sb.errors);
		if (sb.errors == 0)
			$display("column_zone_map_stats: match");
		else
			$display("column_zone_map_stats: mismatch");
		$finish;
	end

endmodule

[column_zone_map_stats.f]
hw/rtl/czm_pkg.sv
hw/rtl/czm_stats_store.sv
hw/rtl/czm_judge.sv
hw/rtl/column_zone_map_stats.sv
tb/tb_column_zone_map_stats.sv
